// ----- hw/rtl/tdb_pkg.sv -----
// Shared types and constants for the terrain detail texture blender.
// Used by every module of the block; depends on nothing.
package tdb_pkg;

    // Texels along each side of a detail tile. The tile position wraps by plain
    // truncation of the position registers, which needs a power of two here.
    localparam int TILE_SIZE = 128;

    localparam int CFG_W     = 23;  // width of the position registers
    localparam int ROWLEN_W  = 13;  // width of the row length register
    localparam int COUNT_W   = 12;  // width of the column counter
    localparam int CFG_IDX_W = 3;   // register index width on the write port
    localparam int OPCODE_W  = 2;
    localparam int LAYER_W   = 2;
    localparam int TADDR_W   = 14;  // texel address field of a load request
    localparam int MIX_W     = 10;  // composition value field
    localparam int CHAN_W    = 8;   // one colour byte
    localparam int TEXEL_W   = 3 * CHAN_W;

    localparam logic [CFG_W-1:0]    STEP_RESET    = 23'd524288;
    localparam logic [CFG_W-1:0]    ORIGIN_RESET  = 23'd0;
    localparam logic [ROWLEN_W-1:0] ROWLEN_RESET  = 13'd256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_BLEND   = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_S     = 3'd0,
        CFG_STEP_T     = 3'd1,
        CFG_ORIGIN_S   = 3'd2,
        CFG_ORIGIN_T   = 3'd3,
        CFG_ROW_LENGTH = 3'd4
    } t_cfg_index;

    // Commands from the request decoder to the tile position generator.
    typedef struct packed {
        logic restart;  // return to the region origin
        logic advance;  // one texel has been issued
    } t_pos_cmd;

endpackage

// ----- hw/rtl/terrain_detail_texture_blend.sv -----
// Top level of the terrain detail texture blender: request decode, configuration
// registers, read pipeline and output register. Depends on tdb_pkg, tdb_store,
// tdb_addr_gen and tdb_blend.
//
//  Channel    Handshake                 Payload
//  ---------  ------------------------  -------------------------------------------
//  request    i_in_valid / o_in_stall   i_opcode, i_layer, i_texel_address,
//                                       i_load_red/green/blue, i_mix_value
//  result     o_out_valid / i_out_stall o_out_red/green/blue, o_row_end
//  config     i_cfg_we                  i_cfg_index, i_cfg_data
//
// One request is taken per cycle unless the output register stalls. A blend request
// reads both layers from the two read ports of the detail memory at its accept edge,
// blends in the next cycle and shows its result from the output register. Loads
// write the memory at their own accept edge, so every later blend sees them; there
// is no clearing pass after reset and unwritten texels read as whatever the memory
// holds. Reset clears the tile position, the column counter and the pipeline valid
// bits and sets the configuration registers to their reset values. A stalled output
// register holds the whole pipeline and stalls requests of every kind.
module terrain_detail_texture_blend #(
    parameter int LAYER_COUNT   = 4,
    parameter int POS_FRAC_BITS = 16,
    parameter int MIX_FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [tdb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tdb_pkg::CFG_W-1:0]        i_cfg_data,
    // requests
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tdb_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [tdb_pkg::LAYER_W-1:0]      i_layer,
    input  logic [tdb_pkg::TADDR_W-1:0]      i_texel_address,
    input  logic [tdb_pkg::CHAN_W-1:0]       i_load_red,
    input  logic [tdb_pkg::CHAN_W-1:0]       i_load_green,
    input  logic [tdb_pkg::CHAN_W-1:0]       i_load_blue,
    input  logic [tdb_pkg::MIX_W-1:0]        i_mix_value,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tdb_pkg::CHAN_W-1:0]       o_out_red,
    output logic [tdb_pkg::CHAN_W-1:0]       o_out_green,
    output logic [tdb_pkg::CHAN_W-1:0]       o_out_blue,
    output logic                             o_row_end
);

    localparam int TILE_BITS   = $clog2(tdb_pkg::TILE_SIZE);
    localparam int POS_W       = TILE_BITS + POS_FRAC_BITS;
    localparam int LAYER_BITS  = $clog2(LAYER_COUNT);
    localparam int OFFS_W      = 2 * TILE_BITS;
    localparam int ADDR_W      = LAYER_BITS + OFFS_W;
    localparam int TILE_TEXELS = tdb_pkg::TILE_SIZE * tdb_pkg::TILE_SIZE;
    localparam int DEPTH       = LAYER_COUNT * TILE_TEXELS;
    localparam int TOP_LAYER   = LAYER_COUNT - 1;
    localparam int CW          = tdb_pkg::CHAN_W;
    localparam int CFG_W       = tdb_pkg::CFG_W;
    localparam int MIX_EXT_W   = MIX_FRAC_BITS + tdb_pkg::MIX_W;

    // Register reset values reduced to the tile span, as a written value is.
    localparam logic [CFG_W+POS_W-1:0] STEP_RST_EXT   =
        (CFG_W+POS_W)'(tdb_pkg::STEP_RESET);
    localparam logic [CFG_W+POS_W-1:0] ORIGIN_RST_EXT =
        (CFG_W+POS_W)'(tdb_pkg::ORIGIN_RESET);

    // ------------------------------------------------------------------
    // Configuration registers. Positions are stored already reduced modulo
    // the tile span, which is a plain truncation to POS_W bits.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]               r_step_s, r_step_t, r_origin_s, r_origin_t;
    logic [tdb_pkg::ROWLEN_W-1:0]   r_row_length;
    logic [CFG_W+POS_W-1:0]         cfg_ext;

    assign cfg_ext = {POS_W'(0), i_cfg_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_s     <= STEP_RST_EXT[POS_W-1:0];
            r_step_t     <= STEP_RST_EXT[POS_W-1:0];
            r_origin_s   <= ORIGIN_RST_EXT[POS_W-1:0];
            r_origin_t   <= ORIGIN_RST_EXT[POS_W-1:0];
            r_row_length <= tdb_pkg::ROWLEN_RESET;
        end else if (i_cfg_we) begin
            unique case (tdb_pkg::t_cfg_index'(i_cfg_index))
                tdb_pkg::CFG_STEP_S:     r_step_s     <= cfg_ext[POS_W-1:0];
                tdb_pkg::CFG_STEP_T:     r_step_t     <= cfg_ext[POS_W-1:0];
                tdb_pkg::CFG_ORIGIN_S:   r_origin_s   <= cfg_ext[POS_W-1:0];
                tdb_pkg::CFG_ORIGIN_T:   r_origin_t   <= cfg_ext[POS_W-1:0];
                tdb_pkg::CFG_ROW_LENGTH: r_row_length <= i_cfg_data[tdb_pkg::ROWLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The pipeline moves as a whole whenever the output register
    // is empty or being taken.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic accept_in;
    logic load_acc, restart_acc, blend_acc;

    assign pipe_en    = !o_out_valid || !i_out_stall;
    assign o_in_stall = !pipe_en;
    assign accept_in  = i_in_valid && pipe_en;

    always_comb begin
        load_acc    = 1'b0;
        restart_acc = 1'b0;
        blend_acc   = 1'b0;
        unique case (tdb_pkg::t_opcode'(i_opcode))
            tdb_pkg::OP_LOAD:    load_acc    = accept_in;
            tdb_pkg::OP_RESTART: restart_acc = accept_in;
            tdb_pkg::OP_BLEND:   blend_acc   = accept_in;
            default: ;  // unknown opcode: no effect
        endcase
    end

    // ------------------------------------------------------------------
    // Tile position generator.
    // ------------------------------------------------------------------
    tdb_pkg::t_pos_cmd    pos_cmd;
    logic [TILE_BITS-1:0] pos_col, pos_row;
    logic                 pos_row_end;

    assign pos_cmd.restart = restart_acc;
    assign pos_cmd.advance = blend_acc;

    tdb_addr_gen #(
        .TILE_BITS     (TILE_BITS),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_addr_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (pos_cmd),
        .i_step_s     (r_step_s),
        .i_step_t     (r_step_t),
        .i_origin_s   (r_origin_s),
        .i_origin_t   (r_origin_t),
        .i_row_length (r_row_length),
        .o_col        (pos_col),
        .o_row        (pos_row),
        .o_row_end    (pos_row_end)
    );

    // ------------------------------------------------------------------
    // Layer selection. The integer part of the composition value picks the
    // lower layer; at or above the top layer both reads hit the top layer
    // and the fraction is dropped, so the output is that layer's texel.
    // ------------------------------------------------------------------
    logic [MIX_EXT_W-1:0]       mix_ext;
    logic [tdb_pkg::MIX_W-1:0]  mix_idx;
    logic                       at_top;
    logic [LAYER_BITS-1:0]      idx0, idx1;
    logic [MIX_FRAC_BITS-1:0]   frac;

    assign mix_ext = {MIX_FRAC_BITS'(0), i_mix_value};
    assign mix_idx = mix_ext[MIX_EXT_W-1:MIX_FRAC_BITS];
    assign at_top  = (mix_idx >= tdb_pkg::MIX_W'(TOP_LAYER));
    assign idx0    = at_top ? LAYER_BITS'(TOP_LAYER) : mix_idx[LAYER_BITS-1:0];
    assign idx1    = at_top ? LAYER_BITS'(TOP_LAYER) : idx0 + LAYER_BITS'(1);
    assign frac    = at_top ? '0 : mix_ext[MIX_FRAC_BITS-1:0];

    // ------------------------------------------------------------------
    // Detail memory. A load is written at its accept edge and a blend reads
    // at its own accept edge; only one request is taken per edge, so a read
    // never meets a write to the same entry and no forwarding is needed.
    // Loads outside the layers or the tile are dropped.
    // ------------------------------------------------------------------
    logic [LAYER_BITS+tdb_pkg::LAYER_W-1:0] load_layer_ext;
    logic [OFFS_W+tdb_pkg::TADDR_W-1:0]     load_addr_ext;
    logic                                   load_in_range;
    logic                                   wr_en;
    logic [ADDR_W-1:0]                      wr_addr, rd_addr_a, rd_addr_b;
    logic [tdb_pkg::TEXEL_W-1:0]            wr_data, texel_a, texel_b;

    assign load_layer_ext = {LAYER_BITS'(0), i_layer};
    assign load_addr_ext  = {OFFS_W'(0), i_texel_address};
    assign load_in_range  = (int'(i_layer) < LAYER_COUNT) &&
                            (int'(i_texel_address) < TILE_TEXELS);
    assign wr_en     = load_acc && load_in_range;
    assign wr_addr   = {load_layer_ext[LAYER_BITS-1:0], load_addr_ext[OFFS_W-1:0]};
    assign wr_data   = {i_load_red, i_load_green, i_load_blue};
    assign rd_addr_a = {idx0, pos_row, pos_col};
    assign rd_addr_b = {idx1, pos_row, pos_col};

    tdb_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (blend_acc),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (texel_a),
        .o_rd_data_b (texel_b)
    );

    // ------------------------------------------------------------------
    // Read stage: side information travels beside the memory read.
    // ------------------------------------------------------------------
    logic                      r_s1_valid;
    logic [MIX_FRAC_BITS-1:0]  r_s1_frac;
    logic                      r_s1_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_valid <= blend_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (blend_acc) begin
            r_s1_frac    <= frac;
            r_s1_row_end <= pos_row_end;
        end
    end

    // ------------------------------------------------------------------
    // Blend and output register.
    // ------------------------------------------------------------------
    logic [tdb_pkg::TEXEL_W-1:0] blended;

    tdb_blend #(
        .MIX_FRAC_BITS (MIX_FRAC_BITS)
    ) u_blend (
        .i_texel_a (texel_a),
        .i_texel_b (texel_b),
        .i_frac    (r_s1_frac),
        .o_texel   (blended)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (pipe_en) begin
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_s1_valid) begin
            o_out_red   <= blended[2*CW +: CW];
            o_out_green <= blended[CW +: CW];
            o_out_blue  <= blended[0 +: CW];
            o_row_end   <= r_s1_row_end;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A restart puts the column position back at the row origin.
    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart_acc |=> (pos_col == $past(r_origin_s[POS_W-1:POS_FRAC_BITS])))
        else $error("restart did not return to the origin column");

    // Every accepted blend reaches the read stage carrying its row end flag.
    a_blend_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blend_acc |=> (r_s1_valid && (r_s1_row_end == $past(pos_row_end))))
        else $error("accepted blend lost before the read stage");

    // A held read stage keeps its item while the output is stalled.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !pipe_en) |=> r_s1_valid)
        else $error("read stage dropped an item under stall");

    // With a row length of zero or one every texel ends its row.
    a_short_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (blend_acc && (r_row_length <= tdb_pkg::ROWLEN_W'(1))) |-> pos_row_end)
        else $error("single texel row did not end");

endmodule

// ----- hw/rtl/tdb_store.sv -----
// Detail texel memory: one write port and two registered read ports.
// Depends on tdb_pkg for the texel width.
module tdb_store #(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [tdb_pkg::TEXEL_W-1:0]  i_wr_data,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr_a,
    input  logic [ADDR_W-1:0]            i_rd_addr_b,
    output logic [tdb_pkg::TEXEL_W-1:0]  o_rd_data_a,
    output logic [tdb_pkg::TEXEL_W-1:0]  o_rd_data_b
);

    logic [tdb_pkg::TEXEL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data is held while no read is issued, so a stalled pipeline keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

// ----- hw/rtl/tdb_addr_gen.sv -----
// Tile position generator: fixed-point column and row positions and the
// column counter that marks the end of a row. Depends on tdb_pkg.
module tdb_addr_gen #(
    parameter int TILE_BITS     = 7,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tdb_pkg::t_pos_cmd              i_cmd,
    input  logic [TILE_BITS+POS_FRAC_BITS-1:0] i_step_s,
    input  logic [TILE_BITS+POS_FRAC_BITS-1:0] i_step_t,
    input  logic [TILE_BITS+POS_FRAC_BITS-1:0] i_origin_s,
    input  logic [TILE_BITS+POS_FRAC_BITS-1:0] i_origin_t,
    input  logic [tdb_pkg::ROWLEN_W-1:0]   i_row_length,
    output logic [TILE_BITS-1:0]           o_col,
    output logic [TILE_BITS-1:0]           o_row,
    output logic                           o_row_end
);

    localparam int POS_W = TILE_BITS + POS_FRAC_BITS;

    logic [POS_W-1:0]                 r_tile_s, n_tile_s;
    logic [POS_W-1:0]                 r_tile_t, n_tile_t;
    logic [tdb_pkg::COUNT_W-1:0]      r_col_count, n_col_count;
    logic [tdb_pkg::ROWLEN_W-1:0]     col_inc;
    logic [tdb_pkg::ROWLEN_W-1:0]     limit;

    // Positions are kept modulo the tile span, which is simply their width.
    assign col_inc   = {1'b0, r_col_count} + tdb_pkg::ROWLEN_W'(1);
    assign limit     = (i_row_length == '0) ? tdb_pkg::ROWLEN_W'(1) : i_row_length;
    assign o_row_end = (col_inc >= limit);
    assign o_col     = r_tile_s[POS_W-1:POS_FRAC_BITS];
    assign o_row     = r_tile_t[POS_W-1:POS_FRAC_BITS];

    always_comb begin
        n_tile_s    = r_tile_s;
        n_tile_t    = r_tile_t;
        n_col_count = r_col_count;
        priority if (i_cmd.restart) begin
            n_tile_s    = i_origin_s;
            n_tile_t    = i_origin_t;
            n_col_count = '0;
        end else if (i_cmd.advance && o_row_end) begin
            n_tile_s    = i_origin_s;
            n_tile_t    = r_tile_t + i_step_t;
            n_col_count = '0;
        end else if (i_cmd.advance) begin
            n_tile_s    = r_tile_s + i_step_s;
            n_col_count = col_inc[tdb_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_s    <= '0;
            r_tile_t    <= '0;
            r_col_count <= '0;
        end else begin
            r_tile_s    <= n_tile_s;
            r_tile_t    <= n_tile_t;
            r_col_count <= n_col_count;
        end
    end

endmodule

// ----- hw/rtl/tdb_blend.sv -----
// Per-channel linear blend of two detail texels, floored toward minus infinity.
// Depends on tdb_pkg for channel and texel widths.
module tdb_blend #(
    parameter int MIX_FRAC_BITS = 8
) (
    input  logic [tdb_pkg::TEXEL_W-1:0] i_texel_a,
    input  logic [tdb_pkg::TEXEL_W-1:0] i_texel_b,
    input  logic [MIX_FRAC_BITS-1:0]    i_frac,
    output logic [tdb_pkg::TEXEL_W-1:0] o_texel
);

    localparam int CW    = tdb_pkg::CHAN_W;
    localparam int SUM_W = MIX_FRAC_BITS + CW + 2;

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [CW-1:0]            a, b;
        logic signed [CW:0]       diff;
        logic signed [SUM_W-1:0]  prod;
        logic signed [SUM_W-1:0]  sum;

        assign a    = i_texel_a[ch*CW +: CW];
        assign b    = i_texel_b[ch*CW +: CW];
        assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
        assign prod = SUM_W'($signed({1'b0, i_frac}) * diff);
        // The exact blend lies between a and b, so the floor fits in one byte.
        assign sum  = $signed({2'b00, a, MIX_FRAC_BITS'(0)}) + prod;
        assign o_texel[ch*CW +: CW] = sum[MIX_FRAC_BITS +: CW];
    end

endmodule

// ----- tb/sv/terrain_detail_texture_blend_test.sv -----
// Self-checking testbench for terrain_detail_texture_blend: directed requests, then
// phases of random requests under several register settings and idle patterns.
// Depends on tdb_pkg and the RTL of the block; reads no files.
module terrain_detail_texture_blend_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tdb_pkg::*;

    // Geometry of the block as instantiated (default parameters).
    localparam int TILE_BITS     = 7;                     // log2 of the tile size
    localparam int TILE_TEXELS   = 1 << (2 * TILE_BITS);
    localparam int LAYERS        = 4;
    localparam int TOP_LAYER     = LAYERS - 1;
    localparam int STORE_DEPTH   = LAYERS * TILE_TEXELS;
    localparam int MIX_FRAC_BITS = 8;

    // The opcode value that the block must ignore.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Run shape and limits.
    localparam int RESET_CYCLES    = 12;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_PHASE      = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;
    localparam int STALL_LIMIT     = 4000;
    localparam int SHOWN_LIMIT     = 200;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LAYER_W-1:0]  layer;
        logic [TADDR_W-1:0]  texel_address;
        logic [CHAN_W-1:0]   load_red;
        logic [CHAN_W-1:0]   load_green;
        logic [CHAN_W-1:0]   load_blue;
        logic [MIX_W-1:0]    mix_value;
    } request_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
    } texel_t;

    typedef struct packed {
        request_t req;
        logic     checked;   // expected texel below is typed in by hand
        texel_t   result;
    } directed_row_t;

    // ------------------------------------------------------------------
    // Signals towards and from the block. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OPCODE_W-1:0]  i_opcode = '0;
    logic [LAYER_W-1:0]   i_layer = '0;
    logic [TADDR_W-1:0]   i_texel_address = '0;
    logic [CHAN_W-1:0]    i_load_red = '0;
    logic [CHAN_W-1:0]    i_load_green = '0;
    logic [CHAN_W-1:0]    i_load_blue = '0;
    logic [MIX_W-1:0]     i_mix_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CHAN_W-1:0]    o_out_red;
    logic [CHAN_W-1:0]    o_out_green;
    logic [CHAN_W-1:0]    o_out_blue;
    logic                 o_row_end;

    terrain_detail_texture_blend i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_layer         (i_layer),
        .i_texel_address (i_texel_address),
        .i_load_red      (i_load_red),
        .i_load_green    (i_load_green),
        .i_load_blue     (i_load_blue),
        .i_mix_value     (i_mix_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_row_end       (o_row_end)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the detail memory, the tile position,
    // the texel count within the current row and the registers. A second map
    // records which texels have been loaded, so that the stimulus never makes
    // the block read a texel whose content is still undefined.
    // ------------------------------------------------------------------
    logic [TEXEL_W-1:0]  detail_texels [STORE_DEPTH];
    bit                  texel_loaded  [STORE_DEPTH];
    logic [CFG_W-1:0]    pos_s = '0;
    logic [CFG_W-1:0]    pos_t = '0;
    logic [COUNT_W-1:0]  texels_in_row = '0;
    logic [CFG_W-1:0]    cfg_step_s = STEP_RESET;
    logic [CFG_W-1:0]    cfg_step_t = STEP_RESET;
    logic [CFG_W-1:0]    cfg_origin_s = ORIGIN_RESET;
    logic [CFG_W-1:0]    cfg_origin_t = ORIGIN_RESET;
    logic [ROWLEN_W-1:0] cfg_row_length = ROWLEN_RESET;

    // Blended texels still owed by the block, oldest first.
    texel_t      pending_texels [$];
    int unsigned fault_count = 0;
    int unsigned shown_faults = 0;
    int          requests_issued = 0;

    // Idle pattern: the sender's share is read by the stimulus process only;
    // the receiver's share is updated by nonblocking assignment because the
    // receiver process samples it on the same edge.
    int tx_idle_pct = 31;
    int rx_idle_pct = 49;

    // Long receiver hold-off: armed by the stimulus, counted by the receiver.
    logic hold_armed = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;

    // The texel under the current tile position: the integer parts of the
    // row and column positions form the address within a layer. The tile
    // span is exactly the range of the 23-bit registers, so the wrap of the
    // position is simply the wrap of the register arithmetic.
    function automatic int read_spot();
        return int'({pos_t[CFG_W-1 -: TILE_BITS], pos_s[CFG_W-1 -: TILE_BITS]});
    endfunction

    // Splits a composition value into the lower layer, the upper layer and the
    // fraction between them. Indexes at or above the top layer pin both layers
    // to the top one, which makes the blend return that layer's texel.
    function automatic void split_mix(input logic [MIX_W-1:0] mix, output int lower,
                                      output int upper, output logic [7:0] frac);
        lower = int'(mix >> MIX_FRAC_BITS);
        frac  = mix[MIX_FRAC_BITS-1:0];
        if (lower >= TOP_LAYER) begin
            lower = TOP_LAYER;
            upper = TOP_LAYER;
            frac  = '0;
        end else begin
            upper = lower + 1;
        end
    endfunction

    // a + frac * (b - a) / 256, floored. The arithmetic shift of the signed
    // product rounds towards minus infinity in both directions.
    function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] a,
                                                      input logic [CHAN_W-1:0] b,
                                                      input logic [7:0] frac);
        int delta;
        delta = int'(b) - int'(a);
        return CHAN_W'(int'(a) + ((int'(frac) * delta) >>> MIX_FRAC_BITS));
    endfunction

    // Advances the predictor by one accepted request and returns the texel that
    // it produces, if any.
    task automatic apply_request(input request_t r, output bit produces,
                                 output texel_t texel);
        int                  lower;
        int                  upper;
        int                  spot;
        logic [7:0]          frac;
        logic [TEXEL_W-1:0]  ta;
        logic [TEXEL_W-1:0]  tb;
        logic [ROWLEN_W-1:0] limit;
        logic [ROWLEN_W-1:0] count;
        produces = 1'b0;
        texel = '0;
        case (r.opcode)
            OP_LOAD: begin
                spot = int'(r.layer) * TILE_TEXELS + int'(r.texel_address);
                detail_texels[spot] = {r.load_red, r.load_green, r.load_blue};
                texel_loaded[spot] = 1'b1;
            end
            OP_RESTART: begin
                pos_s = cfg_origin_s;
                pos_t = cfg_origin_t;
                texels_in_row = '0;
            end
            OP_BLEND: begin
                spot = read_spot();
                split_mix(r.mix_value, lower, upper, frac);
                ta = detail_texels[lower * TILE_TEXELS + spot];
                tb = detail_texels[upper * TILE_TEXELS + spot];
                texel.red   = mix_channel(ta[23:16], tb[23:16], frac);
                texel.green = mix_channel(ta[15:8], tb[15:8], frac);
                texel.blue  = mix_channel(ta[7:0], tb[7:0], frac);
                // A zero row length behaves as one; a row also ends at once when
                // the length has been lowered below the count already reached.
                limit = (cfg_row_length == '0) ? ROWLEN_W'(1) : cfg_row_length;
                count = ROWLEN_W'(texels_in_row) + ROWLEN_W'(1);
                texel.row_end = (count >= limit);
                if (texel.row_end) begin
                    texels_in_row = '0;
                    pos_s = cfg_origin_s;
                    pos_t = pos_t + cfg_step_t;
                end else begin
                    texels_in_row = count[COUNT_W-1:0];
                    pos_s = pos_s + cfg_step_s;
                end
                produces = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender. Each request may be preceded by idle cycles; the valid stays high
    // from one request to the next when no idle cycle falls between them. The
    // request is taken at the first edge where the block does not stall.
    // ------------------------------------------------------------------
    task automatic send_request(input request_t r, input bit fixed, input texel_t fixed_texel);
        bit     produces;
        texel_t texel;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_opcode        <= r.opcode;
        i_layer         <= r.layer;
        i_texel_address <= r.texel_address;
        i_load_red      <= r.load_red;
        i_load_green    <= r.load_green;
        i_load_blue     <= r.load_blue;
        i_mix_value     <= r.mix_value;
        i_in_valid      <= 1'b1;
        do
            @(posedge i_clk);
        while (o_in_stall);
        apply_request(r, produces, texel);
        if (produces)
            pending_texels.push_back(fixed ? fixed_texel : texel);
        if (r.opcode != OP_UNUSED)
            requests_issued++;
    endtask

    // A request with every field random; the caller then sets what matters.
    // The fields that the chosen opcode does not use are left random on purpose.
    function automatic request_t random_request();
        request_t r;
        r.opcode        = OPCODE_W'($urandom_range(0, 3));
        r.layer         = LAYER_W'($urandom_range(0, 3));
        r.texel_address = TADDR_W'($urandom_range(0, TILE_TEXELS - 1));
        r.load_red      = CHAN_W'($urandom);
        r.load_green    = CHAN_W'($urandom);
        r.load_blue     = CHAN_W'($urandom);
        r.mix_value     = MIX_W'($urandom_range(0, (1 << MIX_W) - 1));
        return r;
    endfunction

    // A blend request, preceded by loads of any texel that it would read and
    // that has never been written.
    task automatic send_blend(input request_t r);
        request_t   fill;
        int         lower;
        int         upper;
        int         layer;
        int         spot;
        int         k;
        logic [7:0] frac;
        spot = read_spot();
        split_mix(r.mix_value, lower, upper, frac);
        for (k = 0; k < 2; k++) begin
            layer = (k == 0) ? lower : upper;
            if (!texel_loaded[layer * TILE_TEXELS + spot]) begin
                fill = random_request();
                fill.opcode = OP_LOAD;
                fill.layer = LAYER_W'(layer);
                fill.texel_address = TADDR_W'(spot);
                send_request(fill, 1'b0, '0);
            end
        end
        r.opcode = OP_BLEND;
        send_request(r, 1'b0, '0);
    endtask

    // Drops the valid, waits for every owed texel, then lets the pipeline empty.
    task automatic wait_until_quiet();
        i_in_valid <= 1'b0;
        while (pending_texels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five registers, one per edge, and mirrors them in the predictor.
    task automatic program_block(input logic [CFG_W-1:0] step_s, input logic [CFG_W-1:0] step_t,
                                 input logic [CFG_W-1:0] origin_s,
                                 input logic [CFG_W-1:0] origin_t,
                                 input logic [ROWLEN_W-1:0] row_length);
        t_cfg_index       index [5];
        logic [CFG_W-1:0] value [5];
        int               k;
        index = '{CFG_STEP_S, CFG_STEP_T, CFG_ORIGIN_S, CFG_ORIGIN_T, CFG_ROW_LENGTH};
        value = '{step_s, step_t, origin_s, origin_t, CFG_W'(row_length)};
        for (k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= index[k];
            i_cfg_data  <= value[k];
            @(posedge i_clk);
            case (index[k])
                CFG_STEP_S:     cfg_step_s = value[k];
                CFG_STEP_T:     cfg_step_t = value[k];
                CFG_ORIGIN_S:   cfg_origin_s = value[k];
                CFG_ORIGIN_T:   cfg_origin_t = value[k];
                CFG_ROW_LENGTH: cfg_row_length = value[k][ROWLEN_W-1:0];
                default: begin
                end
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed requests, run at the reset settings (eight-texel step, origin
    // zero, rows of 256). Each blend is preceded by a restart so that it reads
    // texel 0 of the layers loaded at the top. Where the answer is plain to see
    // (a single layer selected, the top layer reached by clamping) it is typed
    // in; the mixed cases are left to the predictor. The request with the
    // unused opcode tries to overwrite a layer; the blend after it proves that
    // it did not. The fields that a request does not use carry noise.
    // ------------------------------------------------------------------
    directed_row_t directed_rows [21] = '{
        '{'{OP_LOAD,    2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd0},    1'b0, '0},
        '{'{OP_LOAD,    2'd1, 14'd0,     8'hff, 8'hff, 8'hff, 10'd1023}, 1'b0, '0},
        '{'{OP_LOAD,    2'd2, 14'd0,     8'h12, 8'h80, 8'hff, 10'd512},  1'b0, '0},
        '{'{OP_LOAD,    2'd3, 14'd0,     8'ha5, 8'h5a, 8'hc3, 10'd768},  1'b0, '0},
        '{'{OP_UNUSED,  2'd3, 14'd0,     8'h11, 8'h22, 8'h33, 10'd1023}, 1'b0, '0},
        '{'{OP_RESTART, 2'd2, 14'd16383, 8'hff, 8'hff, 8'hff, 10'd512},  1'b0, '0},
        '{'{OP_BLEND,   2'd1, 14'd5,     8'h77, 8'h77, 8'h77, 10'd768},
          1'b1, '{8'ha5, 8'h5a, 8'hc3, 1'b0}},
        '{'{OP_RESTART, 2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd0},    1'b0, '0},
        '{'{OP_BLEND,   2'd3, 14'd16383, 8'hff, 8'hff, 8'hff, 10'd0},
          1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{'{OP_RESTART, 2'd1, 14'd8191,  8'h55, 8'haa, 8'h55, 10'd341},  1'b0, '0},
        '{'{OP_BLEND,   2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd1023},
          1'b1, '{8'ha5, 8'h5a, 8'hc3, 1'b0}},
        '{'{OP_RESTART, 2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd0},    1'b0, '0},
        '{'{OP_BLEND,   2'd2, 14'd8192,  8'haa, 8'h55, 8'haa, 10'd255},  1'b0, '0},
        '{'{OP_RESTART, 2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd0},    1'b0, '0},
        '{'{OP_BLEND,   2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd384},  1'b0, '0},
        '{'{OP_RESTART, 2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd0},    1'b0, '0},
        '{'{OP_BLEND,   2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd513},  1'b0, '0},
        '{'{OP_LOAD,    2'd0, 14'd16383, 8'h01, 8'h02, 8'h03, 10'd1023}, 1'b0, '0},
        '{'{OP_LOAD,    2'd3, 14'd16383, 8'hfe, 8'hfd, 8'hfc, 10'd0},    1'b0, '0},
        '{'{OP_RESTART, 2'd0, 14'd0,     8'h00, 8'h00, 8'h00, 10'd0},    1'b0, '0},
        '{'{OP_BLEND,   2'd3, 14'd16383, 8'h00, 8'h00, 8'h00, 10'd767},  1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Stimulus: reset, the directed requests, then eight phases of random
    // requests. Between phases the sender pauses until every owed texel has
    // arrived, and only then are the registers rewritten. The phases cover the
    // register extremes: the smallest and largest steps (the largest wraps the
    // position backwards), the origin at its top, a zero row length, the
    // longest row, and a row length lowered while a row is under way (phase 5
    // opens with a blend, so no restart clears the count first).
    // ------------------------------------------------------------------
    initial begin : stimulus
        request_t r;
        int       phase;
        int       first;
        int       choice;
        int       k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < $size(directed_rows); k++)
            send_request(directed_rows[k].req, directed_rows[k].checked,
                         directed_rows[k].result);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_until_quiet();
            case (phase)
                1: program_block(23'd65536, 23'd65536, 23'd0, 23'd0, 13'd4);
                2: program_block(23'd1, 23'h7fffff, 23'h7fffff, 23'h7fffff, 13'd1);
                3: program_block(23'h7fffff, 23'd1, CFG_W'($urandom), CFG_W'($urandom), 13'd0);
                4: program_block(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                 CFG_W'($urandom), 13'd4096);
                5: program_block(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                 CFG_W'($urandom), 13'd2);
                6: program_block(23'd32768, 23'd98304, CFG_W'($urandom), CFG_W'($urandom),
                                 13'h1fff);
                7: program_block(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                 CFG_W'($urandom), ROWLEN_W'($urandom_range(1, 16)));
                default: begin
                end
            endcase

            // Sender and receiver idle in turn, then neither does.
            tx_idle_pct = (phase < 3) ? 31 : ((phase < 6) ? 49 : 0);
            rx_idle_pct <= (phase < 3) ? 49 : ((phase < 6) ? 31 : 0);

            first = requests_issued;
            while (requests_issued - first < ITEMS_PER_PHASE) begin
                // Once the phase is under way, the receiver holds off for a long
                // stretch while requests keep coming, so the block fills up.
                if (phase == HOLD_PHASE && requests_issued - first >= 10)
                    hold_armed <= 1'b1;
                r = random_request();
                choice = $urandom_range(0, 99);
                if (requests_issued == first || choice < 60) begin
                    send_blend(r);
                end else if (choice < 80) begin
                    r.opcode = OP_LOAD;
                    send_request(r, 1'b0, '0);
                end else if (choice < 88) begin
                    // Refresh a texel that is about to be read.
                    r.opcode = OP_LOAD;
                    r.texel_address = TADDR_W'(read_spot());
                    send_request(r, 1'b0, '0);
                end else if (choice < 95) begin
                    r.opcode = OP_RESTART;
                    send_request(r, 1'b0, '0);
                end else begin
                    r.opcode = OP_UNUSED;
                    send_request(r, 1'b0, '0);
                end
            end
        end

        wait_until_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("terrain_detail_texture_blend_test: done, clean");
        else
            $display("terrain_detail_texture_blend_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls at the current share, or the long hold-off once
    // it has been armed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_armed && !hold_used) begin
            hold_left   <= HOLD_CYCLES;
            hold_used   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest owed texel.
    // ------------------------------------------------------------------
    texel_t oldest_texel;

    task automatic compare_field(input string name, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got);
        if (want !== got) begin
            fault_count++;
            if (shown_faults < SHOWN_LIMIT) begin
                shown_faults++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_texels.size() == 0) begin
                fault_count++;
                if (shown_faults < SHOWN_LIMIT) begin
                    shown_faults++;
                    $display("%0t: texel expected none, got %0h %0h %0h row_end %0b",
                             $time, o_out_red, o_out_green, o_out_blue, o_row_end);
                end
            end else begin
                oldest_texel = pending_texels.pop_front();
                compare_field("red", oldest_texel.red, o_out_red);
                compare_field("green", oldest_texel.green, o_out_green);
                compare_field("blue", oldest_texel.blue, o_out_blue);
                compare_field("row_end", CHAN_W'(oldest_texel.row_end), CHAN_W'(o_row_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted request, accepted result or register write counts
    // as progress. The longest quiet stretch of a correct run is the receiver
    // hold-off; the limit leaves a wide margin above it.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d texels still owed",
                     $time, quiet_cycles, pending_texels.size());
            $display("terrain_detail_texture_blend_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- files.f -----
hw/rtl/tdb_pkg.sv
hw/rtl/tdb_store.sv
hw/rtl/tdb_addr_gen.sv
hw/rtl/tdb_blend.sv
hw/rtl/terrain_detail_texture_blend.sv
tb/sv/terrain_detail_texture_blend_test.sv
